[sv/interval_timer_statistics_bank_core_assert.svh]
// ----------------------------------------------------------------------------
// interval timer statistics bank assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_STATISTICS_BANK_CORE_ASSERT_SVH
`define INTERVAL_TIMER_STATISTICS_BANK_CORE_ASSERT_SVH

`ifndef SYNTH
`define ITSB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ITSB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITSB_ASSERT(label, clk, rstn, prop, msg)
`define ITSB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[sv/itsb_pkg.sv]
// ----------------------------------------------------------------------------
// itsb_pkg
// shared constants, codes and word types of the stopwatch statistics bank
// ----------------------------------------------------------------------------
package itsb_pkg;

    localparam int TIMER_COUNT = 32;
    localparam int STAMP_W     = 48;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);
    localparam int TOTAL_W     = 64;
    localparam int CALLS_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_START    = 2'd1,
        OP_STOP     = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_STATE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DELTA,
        B_UPDATE
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [IDX_W-1:0]   idx;
        logic [STAMP_W-1:0] stamp;
        status_t            status;
        logic               running;
    } cmd_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [TOTAL_W-1:0] total;
        logic [STAMP_W-1:0] min_int;
        logic [STAMP_W-1:0] max_int;
        logic [CALLS_W-1:0] calls;
    } row_t;

    localparam row_t RESET_ROW = '{
        stamp:   '0,
        total:   '0,
        min_int: '1,
        max_int: '0,
        calls:   '0
    };

endpackage

[sv/itsb_front.sv]
// ----------------------------------------------------------------------------
// itsb_front
// accepts words, checks them against the timer control bits and queues them
// ----------------------------------------------------------------------------
module itsb_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [itsb_pkg::IDX_W-1:0]    s_timer_index,
    input  logic [itsb_pkg::STAMP_W-1:0]  s_timestamp,
    input  logic                          q_ready,
    output logic                          q_push,
    output itsb_pkg::cmd_t                q_cmd
);
    import itsb_pkg::*;

    `include "interval_timer_statistics_bank_core_assert.svh"

    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TIMER_COUNT-1:0] active_reg, active_next;
    logic [TIMER_COUNT-1:0] running_reg, running_next;
    logic                   accept;
    logic                   in_range;
    logic                   sel_active;
    logic                   sel_running;
    op_t                    op;
    status_t                status;
    logic [IDX_W-1:0]       idx;
    logic                   run_after;

    assign s_ready     = q_ready;
    assign accept      = s_valid && q_ready;
    assign op          = op_t'(s_op);
    assign in_range    = {1'b0, s_timer_index} < CNT_W'(TIMER_COUNT);
    assign sel_active  = in_range && active_reg[s_timer_index];
    assign sel_running = running_reg[s_timer_index];

    always_comb begin
        count_next   = count_reg;
        active_next  = active_reg;
        running_next = running_reg;
        status       = ST_OK;
        idx          = s_timer_index;
        run_after    = 1'b0;
        case (op)
            OP_REGISTER: begin
                if (count_reg >= CNT_W'(TIMER_COUNT)) begin
                    status = ST_FULL;
                end else begin
                    idx               = count_reg[IDX_W-1:0];
                    count_next        = count_reg + CNT_W'(1);
                    active_next[idx]  = 1'b1;
                    running_next[idx] = 1'b0;
                end
            end
            OP_START: begin
                if (!sel_active || sel_running) begin
                    status = ST_BAD_STATE;
                end else begin
                    running_next[s_timer_index] = 1'b1;
                    run_after                   = 1'b1;
                end
            end
            OP_STOP: begin
                if (!sel_active || !sel_running) begin
                    status = ST_BAD_STATE;
                end else begin
                    running_next[s_timer_index] = 1'b0;
                end
            end
            OP_READ: begin
                if (!sel_active) begin
                    status = ST_BAD_STATE;
                end else begin
                    run_after = sel_running;
                end
            end
            default: begin
                status = ST_BAD_STATE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            active_reg  <= '0;
            running_reg <= '0;
        end else if (accept) begin
            count_reg   <= count_next;
            active_reg  <= active_next;
            running_reg <= running_next;
        end
    end

    assign q_push          = accept;
    assign q_cmd.op        = op;
    assign q_cmd.idx       = idx;
    assign q_cmd.stamp     = s_timestamp;
    assign q_cmd.status    = status;
    assign q_cmd.running   = run_after;

    `ITSB_ASSERT(a_count_matches_active, aclk, aresetn,
        $countones(active_reg) == int'(count_reg),
        "registered count out of step with active bits")
    `ITSB_ASSERT(a_running_needs_active, aclk, aresetn,
        (running_reg & ~active_reg) == '0, "running bit set on an unregistered timer")
    `ITSB_ASSERT(a_full_holds, aclk, aresetn,
        accept && op == OP_REGISTER && count_reg == CNT_W'(TIMER_COUNT)
            |=> count_reg == CNT_W'(TIMER_COUNT) && $stable(active_reg),
        "register on a full table changed state")

endmodule

[sv/itsb_queue.sv]
// ----------------------------------------------------------------------------
// itsb_queue
// short command queue between the classifying front and the update back
// ----------------------------------------------------------------------------
module itsb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  itsb_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output itsb_pkg::cmd_t  pop_cmd
);
    import itsb_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/itsb_exec.sv]
// ----------------------------------------------------------------------------
// itsb_exec
// read-modify-write of the per-timer statistics memory and result register
// ----------------------------------------------------------------------------
module itsb_exec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  itsb_pkg::cmd_t                q_cmd,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [itsb_pkg::IDX_W-1:0]    m_assigned_index,
    output logic [itsb_pkg::TOTAL_W-1:0]  m_total_ticks,
    output logic [itsb_pkg::STAMP_W-1:0]  m_min_ticks,
    output logic [itsb_pkg::STAMP_W-1:0]  m_max_ticks,
    output logic [itsb_pkg::CALLS_W-1:0]  m_call_count,
    output logic                          m_is_running,
    output logic [itsb_pkg::STAMP_W-1:0]  m_last_interval
);
    import itsb_pkg::*;

    `include "interval_timer_statistics_bank_core_assert.svh"

    back_state_t            state_reg, state_next;
    cmd_t                   cmd_reg;
    row_t                   mem [TIMER_COUNT];
    row_t                   rd_row_reg;
    logic                   rd_written_reg;
    logic [TIMER_COUNT-1:0] written_reg;
    logic [STAMP_W-1:0]     delta_reg;
    row_t                   cur_row;
    row_t                   new_row;
    logic [TOTAL_W:0]       sum_wide;
    logic                   cmd_ok;
    logic                   load;
    logic                   wr_en;
    logic                   out_free;

    logic                   m_valid_reg;
    logic [1:0]             m_status_reg;
    logic [IDX_W-1:0]       m_index_reg;
    logic [TOTAL_W-1:0]     m_total_reg;
    logic [STAMP_W-1:0]     m_min_reg;
    logic [STAMP_W-1:0]     m_max_reg;
    logic [CALLS_W-1:0]     m_calls_reg;
    logic                   m_running_reg;
    logic [STAMP_W-1:0]     m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign cmd_ok   = cmd_reg.status == ST_OK;
    assign cur_row  = rd_written_reg ? rd_row_reg : RESET_ROW;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load       = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    state_next = B_DELTA;
                end
            end
            B_DELTA: begin
                state_next = B_UPDATE;
            end
            B_UPDATE: begin
                if (out_free) begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // updated row for start and stop
    always_comb begin
        new_row  = cur_row;
        sum_wide = {1'b0, cur_row.total} + (TOTAL_W + 1)'(delta_reg);
        case (cmd_reg.op)
            OP_START: begin
                new_row.stamp = cmd_reg.stamp;
                if (cur_row.calls != '1) begin
                    new_row.calls = cur_row.calls + CALLS_W'(1);
                end
            end
            OP_STOP: begin
                new_row.total = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                if (delta_reg > cur_row.max_int) begin
                    new_row.max_int = delta_reg;
                end
                if (delta_reg < cur_row.min_int) begin
                    new_row.min_int = delta_reg;
                end
            end
            default: begin
                new_row = cur_row;
            end
        endcase
    end

    assign wr_en = load && cmd_ok && (cmd_reg.op inside {OP_START, OP_STOP});

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cmd_reg.idx] <= new_row;
        end
        if (q_pop) begin
            rd_row_reg <= mem[q_cmd.idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[cmd_reg.idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg        <= q_cmd;
            rd_written_reg <= written_reg[q_cmd.idx];
        end
        if (state_reg == B_DELTA) begin
            delta_reg <= cmd_reg.stamp - cur_row.stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_status_reg <= cmd_reg.status;
            m_index_reg  <= cmd_reg.idx;
            if (cmd_ok) begin
                m_total_reg   <= new_row.total;
                m_min_reg     <= new_row.min_int;
                m_max_reg     <= new_row.max_int;
                m_calls_reg   <= new_row.calls;
                m_running_reg <= cmd_reg.running;
                m_last_reg    <= (cmd_reg.op == OP_STOP) ? delta_reg : '0;
            end else begin
                m_total_reg   <= '0;
                m_min_reg     <= '0;
                m_max_reg     <= '0;
                m_calls_reg   <= '0;
                m_running_reg <= 1'b0;
                m_last_reg    <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_assigned_index = m_index_reg;
    assign m_total_ticks    = m_total_reg;
    assign m_min_ticks      = m_min_reg;
    assign m_max_ticks      = m_max_reg;
    assign m_call_count     = m_calls_reg;
    assign m_is_running     = m_running_reg;
    assign m_last_interval  = m_last_reg;

    `ITSB_ASSERT(a_delta_then_update, aclk, aresetn,
        state_reg == B_DELTA |=> state_reg == B_UPDATE, "update step skipped after delta")
    `ITSB_ASSERT_ALWAYS(a_no_write_in_reset, aclk,
        !aresetn |-> !wr_en || state_reg == B_UPDATE, "statistics write outside update step")

endmodule

[sv/interval_timer_statistics_bank_core.sv]
// ----------------------------------------------------------------------------
// interval_timer_statistics_bank_core
// bank of profiling stopwatches with per-timer interval statistics
// ----------------------------------------------------------------------------
// flow: an accepted word passes the command queue, then the read, delta and
//   update steps on the single-port statistics memory in the back end, which
//   takes a new word only when idle; the update waits for a free result register
// the front takes up to 4 words ahead through the command queue
// reset: synchronous active low; clears the timer table, queue and result valid
//   flag; statistics rows read as their reset values until first written
module interval_timer_statistics_bank_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [itsb_pkg::IDX_W-1:0]    s_timer_index,
    input  logic [itsb_pkg::STAMP_W-1:0]  s_timestamp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [itsb_pkg::IDX_W-1:0]    m_assigned_index,
    output logic [itsb_pkg::TOTAL_W-1:0]  m_total_ticks,
    output logic [itsb_pkg::STAMP_W-1:0]  m_min_ticks,
    output logic [itsb_pkg::STAMP_W-1:0]  m_max_ticks,
    output logic [itsb_pkg::CALLS_W-1:0]  m_call_count,
    output logic                          m_is_running,
    output logic [itsb_pkg::STAMP_W-1:0]  m_last_interval
);
    import itsb_pkg::*;

    logic push;
    logic push_ready;
    cmd_t push_cmd;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    itsb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_timer_index (s_timer_index),
        .s_timestamp   (s_timestamp),
        .q_ready       (push_ready),
        .q_push        (push),
        .q_cmd         (push_cmd)
    );

    itsb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    itsb_exec u_exec (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (pop_valid),
        .q_cmd            (pop_cmd),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_assigned_index (m_assigned_index),
        .m_total_ticks    (m_total_ticks),
        .m_min_ticks      (m_min_ticks),
        .m_max_ticks      (m_max_ticks),
        .m_call_count     (m_call_count),
        .m_is_running     (m_is_running),
        .m_last_interval  (m_last_interval)
    );

endmodule

[sim/tb_interval_timer_statistics_bank_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_timer_statistics_bank_core
// self-checking bench for the stopwatch statistics bank: directed words cover
// unregistered timers, registration, start/stop misuse, stamp wrap and a full
// table; random traffic then runs mostly legal start/stop/read sequences with
// noise mixed in, under several sender and receiver idling mixes. every result
// word is compared field by field with an in-bench prediction
// ----------------------------------------------------------------------------
module tb_interval_timer_statistics_bank_core;

    import itsb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   index;
        logic [TOTAL_W-1:0] total;
        logic [STAMP_W-1:0] shortest;
        logic [STAMP_W-1:0] longest;
        logic [CALLS_W-1:0] calls;
        logic               running;
        logic [STAMP_W-1:0] measured;
    } timer_stats_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_op;
    logic [IDX_W-1:0]     s_timer_index;
    logic [STAMP_W-1:0]   s_timestamp;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_status;
    logic [IDX_W-1:0]     m_assigned_index;
    logic [TOTAL_W-1:0]   m_total_ticks;
    logic [STAMP_W-1:0]   m_min_ticks;
    logic [STAMP_W-1:0]   m_max_ticks;
    logic [CALLS_W-1:0]   m_call_count;
    logic                 m_is_running;
    logic [STAMP_W-1:0]   m_last_interval;

    // bench copy of the timer table
    int unsigned          n_registered;
    bit                   tmr_active  [TIMER_COUNT];
    bit                   tmr_running [TIMER_COUNT];
    logic [STAMP_W-1:0]   tmr_start   [TIMER_COUNT];
    logic [TOTAL_W-1:0]   tmr_total   [TIMER_COUNT];
    logic [STAMP_W-1:0]   tmr_min     [TIMER_COUNT];
    logic [STAMP_W-1:0]   tmr_max     [TIMER_COUNT];
    logic [CALLS_W-1:0]   tmr_calls   [TIMER_COUNT];

    timer_stats_t         expected_results[$];
    logic [STAMP_W-1:0]   tick_now;
    int unsigned          send_idle_pct;
    int unsigned          recv_stall_pct;
    int unsigned          words_sent;
    int unsigned          results_checked;
    int unsigned          error_count;
    int unsigned          cnt_ok;
    int unsigned          cnt_bad_state;
    int unsigned          cnt_full;
    int unsigned          cnt_intervals;
    int unsigned          cnt_wrapped;
    int unsigned          cycle_count;

    interval_timer_statistics_bank_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_timer_index    (s_timer_index),
        .s_timestamp      (s_timestamp),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_assigned_index (m_assigned_index),
        .m_total_ticks    (m_total_ticks),
        .m_min_ticks      (m_min_ticks),
        .m_max_ticks      (m_max_ticks),
        .m_call_count     (m_call_count),
        .m_is_running     (m_is_running),
        .m_last_interval  (m_last_interval)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= 40) begin
            $display("%0t mismatch on result %0d: %s got 0x%0h expected 0x%0h", $realtime,
                     results_checked, what, got, want);
        end
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[STAMP_W-1:0];
    endfunction

    function automatic void reset_timer_table();
        n_registered = 0;
        for (int i = 0; i < TIMER_COUNT; i++) begin
            tmr_active[i]  = 1'b0;
            tmr_running[i] = 1'b0;
            tmr_start[i]   = '0;
            tmr_total[i]   = '0;
            tmr_min[i]     = '1;
            tmr_max[i]     = '0;
            tmr_calls[i]   = '0;
        end
    endfunction

    // applies one word to the bench table and returns the result word it causes
    function automatic timer_stats_t stopwatch_predict(op_t op, logic [IDX_W-1:0] sel,
                                                       logic [STAMP_W-1:0] stamp);
        timer_stats_t       res;
        logic [STAMP_W-1:0] delta;
        logic [TOTAL_W:0]   sum;
        int unsigned        slot;
        res        = '0;
        res.index  = sel;
        res.status = ST_OK;
        delta      = '0;
        slot       = sel;
        if (op == OP_REGISTER) begin
            if (n_registered >= TIMER_COUNT) begin
                res.status = ST_FULL;
                cnt_full++;
                return res;
            end
            slot = n_registered;
            n_registered++;
            tmr_active[slot]  = 1'b1;
            tmr_running[slot] = 1'b0;
        end else if (!tmr_active[slot] || (op == OP_START && tmr_running[slot])
                     || (op == OP_STOP && !tmr_running[slot])) begin
            res.status = ST_BAD_STATE;
            cnt_bad_state++;
            return res;
        end else if (op == OP_START) begin
            tmr_running[slot] = 1'b1;
            tmr_start[slot]   = stamp;
            if (tmr_calls[slot] != '1) begin
                tmr_calls[slot]++;
            end
        end else if (op == OP_STOP) begin
            tmr_running[slot] = 1'b0;
            delta = stamp - tmr_start[slot];
            if (stamp < tmr_start[slot]) begin
                cnt_wrapped++;
            end
            sum = {1'b0, tmr_total[slot]} + delta;
            tmr_total[slot] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            if (delta > tmr_max[slot]) begin
                tmr_max[slot] = delta;
            end
            if (delta < tmr_min[slot]) begin
                tmr_min[slot] = delta;
            end
            cnt_intervals++;
        end
        cnt_ok++;
        res.index    = slot[IDX_W-1:0];
        res.total    = tmr_total[slot];
        res.shortest = tmr_min[slot];
        res.longest  = tmr_max[slot];
        res.calls    = tmr_calls[slot];
        res.running  = tmr_running[slot];
        res.measured = delta;
        return res;
    endfunction

    // entered and left at a falling edge; valid is only touched once per step
    task automatic send_word(op_t op, logic [IDX_W-1:0] sel, logic [STAMP_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_timer_index <= sel;
        s_timestamp   <= stamp;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(stopwatch_predict(op, sel, stamp));
        words_sent++;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        timer_stats_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word, status", m_status, '0);
            end else begin
                want = expected_results.pop_front();
                check_field("status", m_status, want.status);
                check_field("assigned_index", m_assigned_index, want.index);
                check_field("total_ticks", m_total_ticks, want.total);
                check_field("min_ticks", m_min_ticks, want.shortest);
                check_field("max_ticks", m_max_ticks, want.longest);
                check_field("call_count", m_call_count, want.calls);
                check_field("is_running", m_is_running, want.running);
                check_field("last_interval", m_last_interval, want.measured);
            end
            results_checked++;
        end
    end

    task automatic pick_random_word(output op_t op, output logic [IDX_W-1:0] sel,
                                    output logic [STAMP_W-1:0] stamp);
        int unsigned roll;
        int unsigned pick;
        roll  = $urandom_range(99);
        sel   = IDX_W'($urandom_range(TIMER_COUNT - 1));
        stamp = rand_stamp();
        op    = OP_READ;
        if (roll < 7) begin
            op = OP_REGISTER;
        end else if (roll < 85 && n_registered != 0) begin
            pick = $urandom_range(n_registered - 1);
            sel  = pick[IDX_W-1:0];
            if ($urandom_range(99) < 15) begin
                op = OP_READ;
            end else if (tmr_running[pick]) begin
                op = OP_STOP;
                case ($urandom_range(9))
                    0:       stamp = tmr_start[pick];
                    1:       stamp = tmr_start[pick] + rand_stamp();
                    2:       stamp = tmr_start[pick] - 48'($urandom_range(3));
                    default: stamp = tmr_start[pick] + 48'($urandom_range(1, 20000));
                endcase
            end else begin
                op = OP_START;
                case ($urandom_range(19))
                    0:       tick_now = rand_stamp();
                    1:       tick_now = '1 - 48'($urandom_range(2000));
                    default: tick_now = tick_now + 48'($urandom_range(4000));
                endcase
                stamp = tick_now;
            end
        end else begin
            op = op_t'($urandom_range(3));
        end
    endtask

    task automatic test_unregistered_timers();
        send_word(OP_START, 5'd0, 48'd10);
        send_word(OP_STOP, 5'd31, '1);
        send_word(OP_READ, 5'd17, '0);
    endtask

    // the index field is ignored on register
    task automatic test_register_timers();
        send_word(OP_REGISTER, 5'd31, '0);
        send_word(OP_REGISTER, 5'd0, '1);
        send_word(OP_REGISTER, 5'd21, rand_stamp());
    endtask

    task automatic test_start_stop_pairs();
        send_word(OP_START, 5'd0, 48'd1000);
        send_word(OP_START, 5'd0, 48'd1005);
        send_word(OP_STOP, 5'd0, 48'd1250);
        send_word(OP_STOP, 5'd0, 48'd1300);
        send_word(OP_READ, 5'd0, '0);
        send_word(OP_READ, 5'd2, '0);
    endtask

    task automatic test_stamp_wrap();
        send_word(OP_START, 5'd1, 48'hFFFF_FFFF_FFF0);
        send_word(OP_STOP, 5'd1, 48'h10);
        send_word(OP_START, 5'd1, '0);
        send_word(OP_STOP, 5'd1, '1);
        send_word(OP_START, 5'd2, 48'h5555_5555_5555);
        send_word(OP_STOP, 5'd2, 48'h5555_5555_5555);
    endtask

    task automatic test_table_full();
        while (n_registered < TIMER_COUNT) begin
            send_word(OP_REGISTER, 5'($urandom_range(31)), rand_stamp());
        end
        send_word(OP_REGISTER, 5'd0, '0);
        send_word(OP_REGISTER, 5'd31, '1);
    endtask

    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                       int unsigned n_words);
        op_t                op;
        logic [IDX_W-1:0]   sel;
        logic [STAMP_W-1:0] stamp;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_words) begin
            pick_random_word(op, sel, stamp);
            send_word(op, sel, stamp);
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_op            = OP_REGISTER;
        s_timer_index   = '0;
        s_timestamp     = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        tick_now        = '0;
        words_sent      = 0;
        results_checked = 0;
        error_count     = 0;
        cnt_ok          = 0;
        cnt_bad_state   = 0;
        cnt_full        = 0;
        cnt_intervals   = 0;
        cnt_wrapped     = 0;
        cycle_count     = 0;
        reset_timer_table();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_unregistered_timers();
        test_register_timers();
        test_start_stop_pairs();
        test_stamp_wrap();
        test_random_traffic(0, 0, 250);
        test_table_full();
        test_random_traffic(54, 0, 250);
        test_random_traffic(0, 54, 250);
        test_random_traffic(35, 35, 250);

        s_valid        <= 1'b0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);

        $display("stopwatch bank: %0d words sent, %0d results checked, %0d mismatches",
                 words_sent, results_checked, error_count);
        $display("  %0d ok, %0d bad state, %0d table full, %0d intervals (%0d wrapped)",
                 cnt_ok, cnt_bad_state, cnt_full, cnt_intervals, cnt_wrapped);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
